>>> hdl/fan_ctl_pkg.sv
// types, codes and display helpers shared by the fan speed and timer controller
`default_nettype none

package fan_ctl_pkg;

  // event codes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SERIAL = 2'd2;

  // remote key codes
  localparam logic [7:0] KEY_POWER  = 8'h45;
  localparam logic [7:0] KEY_MODE   = 8'h46;
  localparam logic [7:0] KEY_LEFT_A = 8'h40;
  localparam logic [7:0] KEY_LEFT_B = 8'h15;
  localparam logic [7:0] KEY_RGHT_A = 8'h43;
  localparam logic [7:0] KEY_RGHT_B = 8'h09;
  localparam logic [7:0] KEY_D0     = 8'h16;
  localparam logic [7:0] KEY_D1     = 8'h0C;
  localparam logic [7:0] KEY_D2     = 8'h18;
  localparam logic [7:0] KEY_D3     = 8'h5E;
  localparam logic [7:0] KEY_D4     = 8'h08;
  localparam logic [7:0] KEY_D5     = 8'h1C;
  localparam logic [7:0] KEY_D6     = 8'h5A;
  localparam logic [7:0] KEY_D7     = 8'h42;
  localparam logic [7:0] KEY_D8     = 8'h52;
  localparam logic [7:0] KEY_D9     = 8'h4A;

  // speed levels
  localparam logic [7:0] LVL_00  = 8'h00;
  localparam logic [7:0] LVL_20  = 8'h20;
  localparam logic [7:0] LVL_40  = 8'h40;
  localparam logic [7:0] LVL_OFF = 8'h80;
  localparam logic [7:0] LVL_C0  = 8'hC0;
  localparam logic [7:0] LVL_E0  = 8'hE0;
  localparam logic [7:0] LVL_FF  = 8'hFF;

  localparam logic [6:0] MAX_MINUTES = 7'd99;
  localparam logic [6:0] CAP_MINUTES = 7'd90;
  localparam logic [5:0] MAX_SECONDS = 6'd59;

  localparam logic [6:0] SEG_MINUS = 7'h40;
  localparam logic [6:0] SEG_E     = 7'h79;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_code;
    logic [7:0] level_byte;
    logic [7:0] minutes_byte;
    logic [7:0] seconds_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       fan_on;
    logic       countdown_on;
    logic [6:0] minutes_left;
    logic [5:0] seconds_left;
    logic [6:0] seg_level_sign;
    logic [6:0] seg_level_digit;
    logic [6:0] seg_min_tens;
    logic [6:0] seg_min_ones;
    logic [6:0] seg_sec_tens;
    logic [6:0] seg_sec_ones;
  } result_t;

  typedef struct packed {
    logic       running;
    logic       counting;
    logic [7:0] level;
    logic [6:0] minutes;
    logic [5:0] seconds;
  } state_t;

  typedef struct packed {
    logic [6:0] level_sign;
    logic [6:0] level_digit;
    logic [6:0] min_tens;
    logic [6:0] min_ones;
    logic [6:0] sec_tens;
    logic [6:0] sec_ones;
  } disp_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'h0:    s = 7'h3f;
      4'h1:    s = 7'h06;
      4'h2:    s = 7'h5b;
      4'h3:    s = 7'h4f;
      4'h4:    s = 7'h66;
      4'h5:    s = 7'h6d;
      4'h6:    s = 7'h7d;
      4'h7:    s = 7'h07;
      4'h8:    s = 7'h7f;
      4'h9:    s = 7'h6f;
      4'hA:    s = 7'h77;
      4'hB:    s = 7'h7c;
      4'hC:    s = 7'h39;
      4'hD:    s = 7'h5e;
      4'hE:    s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

  // split into decimal digits: x*205 >> 11 is x/10 for all 7-bit values
  function automatic digits_t dec_split(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    digits_t     r;
    prod   = 15'(v) * 15'd205;
    tens   = prod[14:11];
    rem    = v - 7'(tens) * 7'd10;
    r.tens = tens;
    r.ones = rem[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fan_remote_speed_timer_controller.sv
// top level of the fan speed and sleep-timer controller
`default_nettype none

// Fan speed and sleep-timer controller. Each input word is one event: a checked
// remote key code, a one-second tick or a serial command with level, minutes and
// seconds. Every event gives exactly one result word carrying the drive byte, the
// run and countdown flags, the remaining time and six seven-segment codes. An
// event is captured in an input register and applied to the state on its way into
// the result register, so one event is taken every cycle while the output is not
// stalled, and its result is offered from the result register. While a finished
// result waits to be taken the input register holds one more word, after which
// the input is stalled until the result is taken.

module fan_remote_speed_timer_controller (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  fan_ctl_pkg::item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output fan_ctl_pkg::result_t out_data_o
);

  fan_ctl_pkg::item_t   in_q;
  logic                 in_vld_q;
  logic                 in_vld_d;
  logic                 in_load;
  fan_ctl_pkg::state_t  st_q;
  fan_ctl_pkg::state_t  st_d;
  fan_ctl_pkg::disp_t   disp;
  fan_ctl_pkg::result_t out_q;
  fan_ctl_pkg::result_t out_d;
  logic                 out_vld_q;
  logic                 out_vld_d;
  logic                 out_adv;
  logic                 step;

  assign out_adv    = ~out_vld_q | ~out_stall_i;
  assign step       = in_vld_q & out_adv;
  assign in_stall_o = in_vld_q & ~out_adv;
  assign in_load    = in_valid_i & ~in_stall_o;
  assign in_vld_d   = in_load | (in_vld_q & ~out_adv);
  assign out_vld_d  = out_adv ? in_vld_q : out_vld_q;

  fan_ctl_update u_update (
    .cur_i  (st_q),
    .item_i (in_q),
    .nxt_o  (st_d)
  );

  fan_ctl_disp u_disp (
    .st_i   (st_d),
    .disp_o (disp)
  );

  always_comb begin
    out_d.drive_level     = st_d.level;
    out_d.fan_on          = st_d.running;
    out_d.countdown_on    = st_d.counting;
    out_d.minutes_left    = st_d.minutes;
    out_d.seconds_left    = st_d.seconds;
    out_d.seg_level_sign  = disp.level_sign;
    out_d.seg_level_digit = disp.level_digit;
    out_d.seg_min_tens    = disp.min_tens;
    out_d.seg_min_ones    = disp.min_ones;
    out_d.seg_sec_tens    = disp.sec_tens;
    out_d.seg_sec_ones    = disp.sec_ones;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.running  <= 1'b0;
      st_q.counting <= 1'b0;
      st_q.level    <= fan_ctl_pkg::LVL_OFF;
      st_q.minutes  <= 7'd0;
      st_q.seconds  <= 6'd0;
    end else if (step) begin
      st_q <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/fan_ctl_update.sv
// next-state logic: applies one key, tick or serial event to the controller state
`default_nettype none

module fan_ctl_update (
  input  fan_ctl_pkg::state_t cur_i,
  input  fan_ctl_pkg::item_t  item_i,
  output fan_ctl_pkg::state_t nxt_o
);

  fan_ctl_pkg::state_t nx;
  logic                add_en;
  logic [6:0]          add_n;
  logic [7:0]          add_sum;

  // digit keys one to eight add tens of minutes
  always_comb begin
    add_en = 1'b1;
    add_n  = 7'd0;
    unique case (item_i.key_code)
      fan_ctl_pkg::KEY_D1: add_n = 7'd10;
      fan_ctl_pkg::KEY_D2: add_n = 7'd20;
      fan_ctl_pkg::KEY_D3: add_n = 7'd30;
      fan_ctl_pkg::KEY_D4: add_n = 7'd40;
      fan_ctl_pkg::KEY_D5: add_n = 7'd50;
      fan_ctl_pkg::KEY_D6: add_n = 7'd60;
      fan_ctl_pkg::KEY_D7: add_n = 7'd70;
      fan_ctl_pkg::KEY_D8: add_n = 7'd80;
      default:             add_en = 1'b0;
    endcase
  end

  assign add_sum = {1'b0, cur_i.minutes} + {1'b0, add_n};

  always_comb begin
    nx = cur_i;
    case (item_i.opcode)
      fan_ctl_pkg::OP_KEY: begin
        if (item_i.key_code == fan_ctl_pkg::KEY_POWER) begin
          if (!cur_i.running) begin
            nx.running  = 1'b1;
            nx.level    = fan_ctl_pkg::LVL_C0;
            nx.counting = 1'b0;
          end else begin
            nx.running  = 1'b0;
            nx.level    = fan_ctl_pkg::LVL_OFF;
            nx.minutes  = 7'd0;
            nx.seconds  = 6'd0;
            nx.counting = 1'b0;
          end
        end else if (item_i.key_code == fan_ctl_pkg::KEY_MODE) begin
          case (cur_i.level)
            fan_ctl_pkg::LVL_00: nx.level = fan_ctl_pkg::LVL_FF;
            fan_ctl_pkg::LVL_20: nx.level = fan_ctl_pkg::LVL_E0;
            fan_ctl_pkg::LVL_40: nx.level = fan_ctl_pkg::LVL_C0;
            fan_ctl_pkg::LVL_C0: nx.level = fan_ctl_pkg::LVL_40;
            fan_ctl_pkg::LVL_E0: nx.level = fan_ctl_pkg::LVL_20;
            fan_ctl_pkg::LVL_FF: nx.level = fan_ctl_pkg::LVL_00;
            default:             nx.level = cur_i.level;
          endcase
        end else if (item_i.key_code == fan_ctl_pkg::KEY_LEFT_A ||
                     item_i.key_code == fan_ctl_pkg::KEY_LEFT_B) begin
          if (cur_i.running) begin
            case (cur_i.level)
              fan_ctl_pkg::LVL_00: nx.level = fan_ctl_pkg::LVL_20;
              fan_ctl_pkg::LVL_20: nx.level = fan_ctl_pkg::LVL_40;
              fan_ctl_pkg::LVL_40: nx.level = fan_ctl_pkg::LVL_OFF;
              fan_ctl_pkg::LVL_C0: nx.level = fan_ctl_pkg::LVL_OFF;
              fan_ctl_pkg::LVL_E0: nx.level = fan_ctl_pkg::LVL_C0;
              fan_ctl_pkg::LVL_FF: nx.level = fan_ctl_pkg::LVL_E0;
              default:             nx.level = cur_i.level;
            endcase
          end
        end else if (item_i.key_code == fan_ctl_pkg::KEY_RGHT_A ||
                     item_i.key_code == fan_ctl_pkg::KEY_RGHT_B) begin
          if (!cur_i.running) begin
            // switching on goes straight to E0, one step above the C0 that power gives
            nx.running  = 1'b1;
            nx.counting = 1'b0;
            nx.level    = fan_ctl_pkg::LVL_E0;
          end else begin
            case (cur_i.level)
              fan_ctl_pkg::LVL_20:  nx.level = fan_ctl_pkg::LVL_00;
              fan_ctl_pkg::LVL_40:  nx.level = fan_ctl_pkg::LVL_20;
              fan_ctl_pkg::LVL_OFF: nx.level = fan_ctl_pkg::LVL_C0;
              fan_ctl_pkg::LVL_C0:  nx.level = fan_ctl_pkg::LVL_E0;
              fan_ctl_pkg::LVL_E0:  nx.level = fan_ctl_pkg::LVL_FF;
              default:              nx.level = cur_i.level;
            endcase
          end
        end else if (item_i.key_code == fan_ctl_pkg::KEY_D0) begin
          nx.minutes  = 7'd0;
          nx.seconds  = 6'd0;
          nx.counting = 1'b0;
        end else if (item_i.key_code == fan_ctl_pkg::KEY_D9) begin
          nx.minutes  = fan_ctl_pkg::CAP_MINUTES;
          nx.seconds  = 6'd0;
          nx.running  = 1'b1;
          nx.counting = 1'b1;
        end else if (add_en) begin
          if (add_sum <= {1'b0, fan_ctl_pkg::CAP_MINUTES}) begin
            nx.minutes = add_sum[6:0];
            nx.seconds = 6'd0;
          end
          nx.running  = 1'b1;
          nx.counting = 1'b1;
        end
      end
      fan_ctl_pkg::OP_TICK: begin
        if (cur_i.counting) begin
          if (!cur_i.running) begin
            nx.minutes  = 7'd0;
            nx.seconds  = 6'd0;
            nx.counting = 1'b0;
          end else if (cur_i.seconds != 6'd0) begin
            nx.seconds = cur_i.seconds - 6'd1;
          end else if (cur_i.minutes == 7'd0) begin
            nx.running = 1'b0;
          end else begin
            nx.seconds = fan_ctl_pkg::MAX_SECONDS;
            nx.minutes = cur_i.minutes - 7'd1;
          end
        end
      end
      fan_ctl_pkg::OP_SERIAL: begin
        nx.level   = item_i.level_byte;
        nx.running = (item_i.level_byte != fan_ctl_pkg::LVL_OFF);
        if (item_i.minutes_byte <= {1'b0, fan_ctl_pkg::MAX_MINUTES}) begin
          nx.minutes = item_i.minutes_byte[6:0];
        end
        if (item_i.seconds_byte <= {2'b00, fan_ctl_pkg::MAX_SECONDS}) begin
          nx.seconds = item_i.seconds_byte[5:0];
        end
        if (item_i.minutes_byte != 8'd0 || item_i.seconds_byte != 8'd0) begin
          nx.counting = 1'b1;
        end
      end
      default: nx = cur_i;
    endcase
    // fan off forces the idle level and a cleared time
    if (!nx.running) begin
      nx.level   = fan_ctl_pkg::LVL_OFF;
      nx.minutes = 7'd0;
      nx.seconds = 6'd0;
    end
  end

  assign nxt_o = nx;

endmodule

`default_nettype wire

>>> hdl/fan_ctl_disp.sv
// seven-segment codes for the speed level and the remaining time
`default_nettype none

module fan_ctl_disp (
  input  fan_ctl_pkg::state_t st_i,
  output fan_ctl_pkg::disp_t  disp_o
);

  fan_ctl_pkg::digits_t min_dig;
  fan_ctl_pkg::digits_t sec_dig;
  logic [6:0]           s0;
  logic [6:0]           s1;

  assign min_dig = fan_ctl_pkg::dec_split(st_i.minutes);
  assign sec_dig = fan_ctl_pkg::dec_split({1'b0, st_i.seconds});

  always_comb begin
    s0 = fan_ctl_pkg::seg_code(4'd0);
    s1 = fan_ctl_pkg::seg_code(4'd0);
    if (st_i.running) begin
      case (st_i.level)
        fan_ctl_pkg::LVL_00: begin
          s0 = fan_ctl_pkg::SEG_MINUS;
          s1 = fan_ctl_pkg::seg_code(4'd3);
        end
        fan_ctl_pkg::LVL_20: begin
          s0 = fan_ctl_pkg::SEG_MINUS;
          s1 = fan_ctl_pkg::seg_code(4'd2);
        end
        fan_ctl_pkg::LVL_40: begin
          s0 = fan_ctl_pkg::SEG_MINUS;
          s1 = fan_ctl_pkg::seg_code(4'd1);
        end
        fan_ctl_pkg::LVL_OFF: s1 = fan_ctl_pkg::seg_code(4'd0);
        fan_ctl_pkg::LVL_C0:  s1 = fan_ctl_pkg::seg_code(4'd1);
        fan_ctl_pkg::LVL_E0:  s1 = fan_ctl_pkg::seg_code(4'd2);
        fan_ctl_pkg::LVL_FF:  s1 = fan_ctl_pkg::seg_code(4'd3);
        default: begin
          // unknown level shows E E
          s0 = fan_ctl_pkg::SEG_E;
          s1 = fan_ctl_pkg::SEG_E;
        end
      endcase
    end
  end

  assign disp_o.level_sign  = s0;
  assign disp_o.level_digit = s1;
  assign disp_o.min_tens    = fan_ctl_pkg::seg_code(min_dig.tens);
  assign disp_o.min_ones    = fan_ctl_pkg::seg_code(min_dig.ones);
  assign disp_o.sec_tens    = fan_ctl_pkg::seg_code(sec_dig.tens);
  assign disp_o.sec_ones    = fan_ctl_pkg::seg_code(sec_dig.ones);

endmodule

`default_nettype wire
